@@ rtl/smeu_pkg.sv @@
// smeu_pkg: shared types, sizes and opcode helpers for the stack machine execute unit.
// No dependencies; the top level refers to it by scoped names.
package smeu_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int MEM_BYTES   = 65536;
  localparam int MEM_BASE    = 1024;

  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int SADDR_W = $clog2(STACK_DEPTH);
  localparam int BADDR_W = $clog2(MEM_BYTES);

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_PUSHSTR = 5'd1, OP_DROP = 5'd2, OP_ADD = 5'd3, OP_SUB = 5'd4,
    OP_DUMP = 5'd5, OP_DUP = 5'd6, OP_DUP2 = 5'd7, OP_EQ = 5'd8, OP_NE = 5'd9,
    OP_GT = 5'd10, OP_LT = 5'd11, OP_GE = 5'd12, OP_LE = 5'd13, OP_COND = 5'd14,
    OP_MEM = 5'd15, OP_STORE = 5'd16, OP_LOAD = 5'd17, OP_SHL = 5'd18, OP_SHR = 5'd19,
    OP_OR = 5'd20, OP_AND = 5'd21, OP_SWAP = 5'd22, OP_OVER = 5'd23
  } op_t;

  typedef enum logic [1:0] {
    FLT_OK = 2'd0, FLT_UNDER = 2'd1, FLT_OVER = 2'd2, FLT_ADDR = 2'd3
  } fault_t;

  // Operands an opcode needs on the stack
  function automatic logic [1:0] op_need(input logic [4:0] op);
    logic [1:0] n;
    n = 2'd0;
    case (op)
      OP_PUSH, OP_PUSHSTR, OP_MEM: n = 2'd0;
      OP_DROP, OP_DUMP, OP_DUP, OP_COND, OP_LOAD: n = 2'd1;
      default: n = (op < 5'd24) ? 2'd2 : 2'd0;
    endcase
    return n;
  endfunction

  // Net change of depth per opcode
  function automatic logic signed [2:0] op_grow(input logic [4:0] op);
    logic signed [2:0] g;
    g = 3'sd0;
    case (op)
      OP_PUSH, OP_DUP, OP_MEM, OP_OVER: g = 3'sd1;
      OP_PUSHSTR, OP_DUP2: g = 3'sd2;
      OP_STORE: g = -3'sd2;
      OP_LOAD, OP_SWAP: g = 3'sd0;
      default: g = (op < 5'd24) ? -3'sd1 : 3'sd0;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/smeu_if.sv @@
// smeu_if: valid/ready channel interfaces for instruction items and result items.
// Depends on nothing.
interface smeu_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  opcode;
  logic [63:0] immediate;
  logic [15:0] string_length;
  logic [15:0] string_address;
  modport source (output valid, opcode, immediate, string_length, string_address,
                  input ready);
  modport sink   (input valid, opcode, immediate, string_length, string_address,
                  output ready);
endinterface

interface smeu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] popped_value;
  logic        value_valid;
  logic        branch_taken;
  logic [1:0]  fault;
  modport source (output valid, popped_value, value_valid, branch_taken, fault,
                  input ready);
  modport sink   (input valid, popped_value, value_valid, branch_taken, fault,
                  output ready);
endinterface

@@ rtl/smeu_ram.sv @@
// smeu_ram: generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module smeu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/stack_machine_execute_unit.sv @@
// stack_machine_execute_unit: top level; stack kept as two top registers over a stack RAM.
// Depends on smeu_pkg, smeu_if (channels) and smeu_ram (stack and byte memories).
//
//   channel | modport     | transfer when
//   in_ch   | sink        | valid & ready, one instruction
//   out_ch  | source      | valid & ready, one result per instruction
//
// Most instructions complete in ST_RUN. pushstr and dup2 pass through ST_SPILL (second
// stack write), store through ST_REFILL (stack RAM refill), load through ST_LOADWB (byte read).
// After reset a clearing pass writes zero to every byte (MEM_BYTES, 65536),
// with in_ch.ready low. out_ch is a register: a new instruction is taken while a
// result waits, as long as the sink takes that result in the same cycle.
module stack_machine_execute_unit (
  input  logic             clk,
  input  logic             rst_n,
  smeu_in_if.sink          in_ch,
  smeu_out_if.source       out_ch
);

  localparam int CW = smeu_pkg::CNT_W;
  localparam int AW = smeu_pkg::SADDR_W;
  localparam int BW = smeu_pkg::BADDR_W;

  typedef enum logic [2:0] {ST_CLEAR, ST_RUN, ST_SPILL, ST_REFILL, ST_LOADWB} state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [63:0]   t_r, t_nxt, s_r, s_nxt, spill_r, spill_nxt;
  logic [BW-1:0] clr_r, clr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   popped_r, popped_nxt;
  logic          vv_r, vv_nxt, br_r, br_nxt;
  logic [1:0]    fault_r, fault_nxt;
  logic          byp_r;
  logic [63:0]   bypd_r;

  logic          in_ready, acc, known, exec;
  logic [4:0]    op;
  logic [CW+1:0] sum;
  logic [63:0]   u, r;
  logic          st_we, b_we;
  logic [AW-1:0] st_wa, st_ra;
  logic [63:0]   st_wd, st_rd;
  logic [BW-1:0] b_wa;
  logic [7:0]    b_wd, b_rd;
  smeu_pkg::fault_t flt;

  smeu_ram #(.WIDTH(64), .DEPTH(smeu_pkg::STACK_DEPTH)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd)
  );

  smeu_ram #(.WIDTH(8), .DEPTH(smeu_pkg::MEM_BYTES)) u_bytes (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(t_r[BW-1:0]), .rdata(b_rd)
  );

  assign in_ready         = (state_r == ST_RUN) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready      = in_ready;
  assign acc              = in_ch.valid && in_ready;
  assign op               = in_ch.opcode;
  assign known            = (op < 5'd24);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.value_valid  = vv_r;
  assign out_ch.branch_taken = br_r;
  assign out_ch.fault        = fault_r;

  // Third entry from the top, forwarded when written in the cycle it was read
  assign u = byp_r ? bypd_r : st_rd;

  // Classify the instruction: fault priority underflow, overflow, address
  always_comb begin
    logic signed [2:0] g;
    g   = smeu_pkg::op_grow(op);
    sum = {2'b00, n_r} + {{(CW - 1){g[2]}}, g};
    if (!known) begin
      flt = smeu_pkg::FLT_OK;
    end else if (n_r < CW'(smeu_pkg::op_need(op))) begin
      flt = smeu_pkg::FLT_UNDER;
    end else if (sum > (CW + 2)'(smeu_pkg::STACK_DEPTH)) begin
      flt = smeu_pkg::FLT_OVER;
    end else if ((op == smeu_pkg::OP_STORE && s_r >= 64'(smeu_pkg::MEM_BYTES)) ||
                 (op == smeu_pkg::OP_LOAD && t_r >= 64'(smeu_pkg::MEM_BYTES))) begin
      flt = smeu_pkg::FLT_ADDR;
    end else begin
      flt = smeu_pkg::FLT_OK;
    end
    exec = acc && known && (flt == smeu_pkg::FLT_OK);
  end

  // Binary operation result, S op T
  always_comb begin
    case (smeu_pkg::op_t'(op))
      smeu_pkg::OP_ADD: r = s_r + t_r;
      smeu_pkg::OP_SUB: r = s_r - t_r;
      smeu_pkg::OP_EQ:  r = {63'd0, s_r == t_r};
      smeu_pkg::OP_NE:  r = {63'd0, s_r != t_r};
      smeu_pkg::OP_GT:  r = {63'd0, $signed(s_r) > $signed(t_r)};
      smeu_pkg::OP_LT:  r = {63'd0, $signed(s_r) < $signed(t_r)};
      smeu_pkg::OP_GE:  r = {63'd0, $signed(s_r) >= $signed(t_r)};
      smeu_pkg::OP_LE:  r = {63'd0, $signed(s_r) <= $signed(t_r)};
      smeu_pkg::OP_SHL: r = s_r << t_r[5:0];
      smeu_pkg::OP_SHR: r = 64'($signed(s_r) >>> t_r[5:0]);
      smeu_pkg::OP_OR:  r = s_r | t_r;
      smeu_pkg::OP_AND: r = s_r & t_r;
      default:          r = t_r;
    endcase
  end

  // Next state of the top registers, the stack RAM ports and the result
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    t_nxt         = t_r;
    s_nxt         = s_r;
    spill_nxt     = spill_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    popped_nxt    = popped_r;
    vv_nxt        = vv_r;
    br_nxt        = br_r;
    fault_nxt     = fault_r;
    st_we         = 1'b0;
    st_wa         = AW'(n_r - CW'(2));
    st_wd         = s_r;
    st_ra         = AW'(n_r - CW'(3));
    b_we          = 1'b0;
    b_wa          = s_r[BW-1:0];
    b_wd          = t_r[7:0];

    // Drop the result once taken, load a fresh one on every transfer in
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (acc) begin
      out_valid_nxt = 1'b1;
      popped_nxt    = 64'd0;
      vv_nxt        = 1'b0;
      br_nxt        = 1'b0;
      fault_nxt     = flt;
    end

    case (state_r)
      ST_CLEAR: begin
        b_we    = 1'b1;
        b_wa    = clr_r;
        b_wd    = 8'd0;
        clr_nxt = clr_r + BW'(1);
        if (clr_r == BW'(smeu_pkg::MEM_BYTES - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (exec) begin
          n_nxt = sum[CW-1:0];
          // Pushes spill S below the top pair; refills read the new third entry
          st_we = (n_r >= CW'(2));
          st_ra = AW'(sum[CW-1:0] - CW'(3));
          case (smeu_pkg::op_t'(op))
            smeu_pkg::OP_PUSH: begin
              s_nxt = t_r;
              t_nxt = in_ch.immediate;
            end
            smeu_pkg::OP_MEM: begin
              s_nxt = t_r;
              t_nxt = 64'(smeu_pkg::MEM_BASE);
            end
            smeu_pkg::OP_PUSHSTR: begin
              spill_nxt = t_r;
              s_nxt     = {48'd0, in_ch.string_length};
              t_nxt     = {48'd0, in_ch.string_address};
              state_nxt = ST_SPILL;
            end
            smeu_pkg::OP_DUP: begin
              s_nxt = t_r;
            end
            smeu_pkg::OP_DUP2: begin
              spill_nxt = t_r;
              state_nxt = ST_SPILL;
            end
            smeu_pkg::OP_OVER: begin
              s_nxt = t_r;
              t_nxt = s_r;
            end
            smeu_pkg::OP_SWAP: begin
              st_we = 1'b0;
              s_nxt = t_r;
              t_nxt = s_r;
            end
            smeu_pkg::OP_LOAD: begin
              st_we     = 1'b0;
              state_nxt = ST_LOADWB;
            end
            smeu_pkg::OP_STORE: begin
              st_we     = 1'b0;
              b_we      = 1'b1;
              t_nxt     = u;
              st_ra     = AW'(n_r - CW'(4));
              state_nxt = ST_REFILL;
            end
            smeu_pkg::OP_DROP, smeu_pkg::OP_DUMP: begin
              st_we      = 1'b0;
              popped_nxt = t_r;
              vv_nxt     = 1'b1;
              t_nxt      = s_r;
              s_nxt      = u;
            end
            smeu_pkg::OP_COND: begin
              st_we  = 1'b0;
              br_nxt = (t_r == 64'd0);
              t_nxt  = s_r;
              s_nxt  = u;
            end
            default: begin
              st_we = 1'b0;
              t_nxt = r;
              s_nxt = u;
            end
          endcase
        end
      end
      ST_SPILL: begin
        // Second write of a two-entry push: old top goes to RAM entry n_r - 3 of the new depth
        st_we     = (n_r >= CW'(3));
        st_wa     = AW'(n_r - CW'(3));
        st_wd     = spill_r;
        state_nxt = ST_RUN;
      end
      ST_REFILL: begin
        s_nxt     = u;
        state_nxt = ST_RUN;
      end
      ST_LOADWB: begin
        t_nxt     = {56'd0, b_rd};
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // Hold state, top registers and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      n_r         <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      byp_r       <= st_we && (st_wa == st_ra);
    end
    t_r      <= t_nxt;
    s_r      <= s_nxt;
    spill_r  <= spill_nxt;
    popped_r <= popped_nxt;
    vv_r     <= vv_nxt;
    br_r     <= br_nxt;
    fault_r  <= fault_nxt;
    bypd_r   <= st_wd;
  end

`ifndef ASSERT_OFF
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(smeu_pkg::STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ch.ready)
    else $error("instruction taken during clearing pass");

  a_store_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && exec && op == smeu_pkg::OP_STORE) |=> (state_r == ST_REFILL))
    else $error("store not followed by refill");

  a_fault_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && flt != smeu_pkg::FLT_OK) |=> (n_r == $past(n_r) && state_r == ST_RUN))
    else $error("faulting instruction changed the stack");
`endif

endmodule
